// ===== rtl/pafb_pkg.sv =====
// Shared types, constants and codes for the partition allocator.
package pafb_pkg;

  localparam int unsigned MaxPartitions  = 16;
  localparam int unsigned SizeBits       = 16;
  localparam logic [15:0] MemSizeReset   = 16'd512;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_BADSIZE  = 3'd2,
    ST_BADINDEX = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_FIT_POLICY  = 1'b0,
    CFG_MEMORY_SIZE = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_SHIFT_UP,
    S_SPLIT,
    S_FREE_LO,
    S_FREE_HI,
    S_SHIFT_DN,
    S_RESULT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_size;
    logic [3:0]  partition_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] block_address;
    logic [15:0] block_size;
    logic [3:0]  block_number;
    logic [4:0]  partition_count;
  } out_item_t;

endpackage

// ===== rtl/pafb_ctrl.sv =====
// Sequencer that scans, splits and merges the partition table one entry a cycle.
module pafb_ctrl #(
  parameter int unsigned MAX_PARTITIONS = pafb_pkg::MaxPartitions,
  parameter int unsigned SIZE_BITS      = pafb_pkg::SizeBits
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  pafb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pafb_pkg::out_item_t out_data
);
  import pafb_pkg::*;

  localparam int unsigned IW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTITIONS + 1);

  logic [SIZE_BITS-1:0] start_r [MAX_PARTITIONS];
  logic [SIZE_BITS-1:0] size_r  [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] busy_r;
  logic [CW-1:0]        count_r;
  logic                 policy_r;

  state_t               state_r, state_nxt;
  in_item_t             item_r;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        pick_r, pick_nxt;
  logic                 found_r, found_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic [IW-1:0]        rm_r, rm_nxt;
  logic                 hi_pend_r, hi_pend_nxt;
  logic [2:0]           st_r, st_nxt;
  out_item_t            out_r;
  logic                 out_valid_r;

  logic [IW-1:0]        idx_i;
  logic [SIZE_BITS-1:0] req;
  logic                 fits;
  logic [SIZE_BITS:0]   merged;

  assign idx_i = idx_r[IW-1:0];
  assign req   = SIZE_BITS'(item_r.request_size);
  // shared compare unit: current entry against request and against best pick
  assign fits  = !busy_r[idx_i] && (size_r[idx_i] >= req) &&
                 (!found_r || (size_r[idx_i] < size_r[pick_r]));
  assign merged = {1'b0, size_r[rm_r - 1'b1]} + {1'b0, size_r[rm_r]};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    pick_nxt    = pick_r;
    found_nxt   = found_r;
    k_nxt       = k_r;
    rm_nxt      = rm_r;
    hi_pend_nxt = hi_pend_r;
    st_nxt      = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          pick_nxt  = '0;
          st_nxt    = ST_OK;
          k_nxt     = IW'(in_data.partition_number);
          if (in_data.opcode == OP_ALLOC) begin
            if (in_data.request_size == '0) begin
              st_nxt    = ST_BADSIZE;
              state_nxt = S_RESULT;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if ({1'b0, in_data.partition_number} >= 5'(count_r) ||
                       32'(in_data.partition_number) >= MAX_PARTITIONS) begin
            st_nxt    = ST_BADINDEX;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_FREE_LO;
          end
        end
      end
      S_SCAN: begin
        if (idx_r >= count_r || (found_r && !policy_r)) begin
          state_nxt = S_PLACE;
        end else begin
          if (fits) begin
            found_nxt = 1'b1;
            pick_nxt  = idx_i;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_PLACE: begin
        idx_nxt = count_r;
        if (!found_r) begin
          st_nxt    = ST_NOSPACE;
          state_nxt = S_RESULT;
        end else if (size_r[pick_r] == req) begin
          state_nxt = S_RESULT;
        end else if (32'(count_r) >= MAX_PARTITIONS) begin
          st_nxt    = ST_FULL;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SHIFT_UP;
        end
      end
      S_SHIFT_UP: begin
        if (idx_r <= CW'(pick_r) + 1'b1) state_nxt = S_SPLIT;
        else idx_nxt = idx_r - 1'b1;
      end
      S_SPLIT: begin
        k_nxt     = pick_r;
        state_nxt = S_RESULT;
      end
      S_FREE_LO: begin
        hi_pend_nxt = 1'b1;
        if (k_r != '0 && !busy_r[k_r - 1'b1]) begin
          rm_nxt    = k_r;
          idx_nxt   = CW'(k_r);
          k_nxt     = k_r - 1'b1;
          state_nxt = S_SHIFT_DN;
        end else begin
          state_nxt = S_FREE_HI;
        end
      end
      S_FREE_HI: begin
        hi_pend_nxt = 1'b0;
        if (CW'(k_r) + 1'b1 < count_r && !busy_r[k_r + 1'b1]) begin
          rm_nxt    = k_r + 1'b1;
          idx_nxt   = CW'(k_r) + 1'b1;
          state_nxt = S_SHIFT_DN;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SHIFT_DN: begin
        if (idx_r + 1'b1 >= count_r) state_nxt = hi_pend_r ? S_FREE_HI : S_RESULT;
        else idx_nxt = idx_r + 1'b1;
      end
      S_RESULT: state_nxt = S_OUT;
      S_OUT: if (!out_valid_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b0;
      count_r     <= CW'(1);
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      hi_pend_r   <= 1'b0;
      start_r[0]  <= '0;
      size_r[0]   <= SIZE_BITS'(MemSizeReset);
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      pick_r    <= pick_nxt;
      found_r   <= found_nxt;
      k_r       <= k_nxt;
      rm_r      <= rm_nxt;
      hi_pend_r <= hi_pend_nxt;
      st_r      <= st_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == S_IDLE && in_valid) item_r <= in_data;
      if (cfg_we) begin
        if (cfg_index == CFG_FIT_POLICY) begin
          policy_r <= cfg_data[0];
        end else begin
          start_r[0] <= '0;
          size_r[0]  <= SIZE_BITS'(cfg_data);
          busy_r     <= '0;
          count_r    <= CW'(1);
        end
      end
      unique case (state_r)
        S_PLACE: if (found_r && size_r[pick_r] == req) busy_r[pick_r] <= 1'b1;
        S_SHIFT_UP: begin
          // move entry idx-1 up one place
          if (idx_r > CW'(pick_r) + 1'b1) begin
            start_r[idx_i] <= start_r[idx_i - 1'b1];
            size_r[idx_i]  <= size_r[idx_i - 1'b1];
            busy_r[idx_i]  <= busy_r[idx_i - 1'b1];
          end
        end
        S_SPLIT: begin
          start_r[pick_r + 1'b1] <= start_r[pick_r] + req;
          size_r[pick_r + 1'b1]  <= size_r[pick_r] - req;
          busy_r[pick_r + 1'b1]  <= 1'b0;
          size_r[pick_r]         <= req;
          busy_r[pick_r]         <= 1'b1;
          count_r                <= count_r + 1'b1;
        end
        S_FREE_LO: busy_r[k_r] <= 1'b0;
        S_SHIFT_DN: begin
          if (idx_r == CW'(rm_r)) size_r[rm_r - 1'b1] <= merged[SIZE_BITS-1:0];
          if (idx_r + 1'b1 < count_r) begin
            start_r[idx_i] <= start_r[idx_i + 1'b1];
            size_r[idx_i]  <= size_r[idx_i + 1'b1];
            busy_r[idx_i]  <= busy_r[idx_i + 1'b1];
          end else begin
            count_r <= count_r - 1'b1;
          end
        end
        S_RESULT: begin
          out_valid_r           <= 1'b1;
          out_r.status          <= st_r;
          out_r.partition_count <= 5'(count_r);
          if (st_r == ST_OK) begin
            out_r.block_address <= 16'(start_r[k_r]);
            out_r.block_size    <= 16'(size_r[k_r]);
            out_r.block_number  <= 4'(k_r);
            if (item_r.opcode == OP_ALLOC) begin
              out_r.block_address <= 16'(start_r[pick_r]);
              out_r.block_size    <= 16'(req);
              out_r.block_number  <= 4'(pick_r);
            end
          end else begin
            out_r.block_address <= '0;
            out_r.block_size    <= '0;
            out_r.block_number  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && 32'(count_r) <= MAX_PARTITIONS)
    else $error("partition count out of range");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESULT |=> out_valid_r)
    else $error("result not presented");
  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall)
    else $error("input taken while busy");
  a_split_grow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPLIT && !cfg_we |=> count_r == $past(count_r) + 1'b1)
    else $error("split did not grow table");
`endif
endmodule

// ===== rtl/partition_allocator_first_best_fit_top.sv =====
// Top level of the first-fit / best-fit partition allocator.
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_data (opcode, request_size, partition_number)
// out     | out | out_valid/out_stall| out_data (status, address, size, number, count)
// cfg     | in  | cfg_we             | cfg_index, cfg_data
// An allocation scans one entry a cycle through the shared compare unit, then shifts
// the table up one entry a cycle; a free shifts the table down to merge free neighbours.
// Reset is synchronous; the table holds one free partition of 512 units.
// After acceptance in_stall stays high until the sequencer is idle again, once out_valid has dropped.
module partition_allocator_first_best_fit_top #(
  parameter int unsigned MAX_PARTITIONS = pafb_pkg::MaxPartitions,
  parameter int unsigned SIZE_BITS      = pafb_pkg::SizeBits
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  pafb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pafb_pkg::out_item_t out_data
);
  import pafb_pkg::*;

  pafb_ctrl #(.MAX_PARTITIONS(MAX_PARTITIONS), .SIZE_BITS(SIZE_BITS)) u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );
endmodule
